[design/dlc_pkg.sv]
// shared constants for the depth level classifier
package dlc_pkg;

  localparam int DEPTH_W = 32;
  localparam int TOL_W   = 31;
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FN_CLASSIFY = 2'd0;
  localparam func_t FN_APPEND   = 2'd1;
  localparam func_t FN_CLEAR    = 2'd2;
  localparam func_t FN_NONE     = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_TOL  = 1'b1;

  localparam logic MODE_DISCOVER = 1'b0;
  localparam logic MODE_PRESET   = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd6554;

endpackage

[design/depth_level_classifier.sv]
// depth level classifier: level table memory with a sequential scan per classify request
//
// A request carries a function code in s_tuser and a signed Q16.16 depth in s_tdata.
// Classify requests read the stored levels one per cycle from a table memory with a
// registered read; a classify request goes through accept, a scan of all stored
// levels and a finish step that waits for a free output register; append, clear and
// unused requests go through accept and finish. One request is handled at a time;
// the result sits in an output register, so a new request is taken while an earlier
// result still waits. Clear resets only the fill count, so no clearing pass runs after
// reset. Write mode and tolerance only while the block is idle.
module depth_level_classifier #(
  parameter int MAX_LEVELS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [dlc_pkg::DEPTH_W-1:0] s_tdata,   // [31:0] depth_value
  input  logic [dlc_pkg::FUNC_W-1:0]  s_tuser,   // [1:0] func
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [6:0] level_index, [13:7] level_count,
                                                 // [15:14] status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [dlc_pkg::TOL_W-1:0]   cfg_data
);
  import dlc_pkg::*;

  localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW = $clog2(MAX_LEVELS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]              state;
  logic                    mode;
  logic [TOL_W-1:0]        tolerance;
  logic [CW-1:0]           total;
  logic [CW-1:0]           rd_ptr;
  logic                    pend_v;
  logic [AW-1:0]           pend_idx;
  logic                    hit;
  logic [AW-1:0]           hit_idx;
  func_t                   func;
  logic signed [DEPTH_W-1:0] z;

  logic [DEPTH_W-1:0]      mem [MAX_LEVELS];
  logic signed [DEPTH_W-1:0] rdata;
  logic                    mem_we;

  logic [IDX_W-1:0]        out_index;
  logic [CNT_W-1:0]        out_count;
  status_t                 out_status;

  logic                    full;
  logic                    out_free;
  logic                    in_take;
  logic signed [DEPTH_W:0] diff;
  logic [DEPTH_W:0]        adiff;
  logic                    near;
  logic                    below;

  logic                    res_neg;
  logic [CW-1:0]           res_idx;
  status_t                 res_status;
  logic [CW-1:0]           total_next;
  logic [CW+IDX_W-1:0]     idx_ext;
  logic [CW+CNT_W-1:0]     cnt_ext;

  assign full      = (total == CW'(MAX_LEVELS));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign in_take   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign diff  = {z[DEPTH_W-1], z} - {rdata[DEPTH_W-1], rdata};
  assign adiff = diff[DEPTH_W] ? (DEPTH_W+1)'(-diff) : diff;
  assign near  = adiff < {2'b00, tolerance};
  assign below = z > rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[total[AW-1:0]] <= z;
    end
    rdata <= mem[rd_ptr[AW-1:0]];
  end

  always_comb begin
    res_neg    = 1'b1;
    res_idx    = '0;
    res_status = ST_OK;
    total_next = total;
    mem_we     = 1'b0;
    unique case (func)
      FN_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          res_neg    = 1'b0;
          res_idx    = total;
          total_next = total + CW'(1);
        end
      end
      FN_CLEAR: begin
        total_next = '0;
      end
      FN_CLASSIFY: begin
        if (mode == MODE_DISCOVER) begin
          priority if (hit) begin
            res_neg = 1'b0;
            res_idx = CW'(hit_idx);
          end else if (full) begin
            res_status = ST_FULL;
          end else begin
            mem_we     = 1'b1;
            total_next = total + CW'(1);
            res_neg    = (tolerance == '0);
            res_idx    = total;
          end
        end else begin
          priority if (total == '0) begin
            res_status = ST_EMPTY;
          end else if (hit) begin
            res_neg = 1'b0;
            res_idx = CW'(hit_idx);
          end else begin
            res_neg = 1'b0;
            res_idx = total - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    mem_we = mem_we && (state == S_FIN) && out_free;
  end

  assign idx_ext = {{IDX_W{1'b0}}, res_idx};
  assign cnt_ext = {{CNT_W{1'b0}}, total_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_DISCOVER;
      tolerance <= TOL_RESET;
      total     <= '0;
      rd_ptr    <= '0;
      pend_v    <= 1'b0;
      hit       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE: mode      <= cfg_data[0];
          REG_TOL:  tolerance <= cfg_data;
          default: begin
          end
        endcase
      end
      if ((state == S_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            func   <= s_tuser;
            z      <= s_tdata;
            hit    <= 1'b0;
            rd_ptr <= '0;
            pend_v <= 1'b0;
            state  <= (s_tuser == FN_CLASSIFY) ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (pend_v) begin
            if (mode == MODE_DISCOVER) begin
              if (near) begin
                hit     <= 1'b1;
                hit_idx <= pend_idx;
              end
            end else if (!hit && below) begin
              hit     <= 1'b1;
              hit_idx <= pend_idx;
            end
          end
          if (rd_ptr < total) begin
            pend_v   <= 1'b1;
            pend_idx <= rd_ptr[AW-1:0];
            rd_ptr   <= rd_ptr + CW'(1);
          end else begin
            pend_v <= 1'b0;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_index  <= res_neg ? {IDX_W{1'b1}} : idx_ext[IDX_W-1:0];
            out_count  <= cnt_ext[CNT_W-1:0];
            out_status <= res_status;
            total      <= total_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {out_status, out_count, out_index};

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_LEVELS))
    else $error("level count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_FIN) && !full)
    else $error("table write outside finish or into full table");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (state == S_SCAN))
    else $error("read pending outside scan");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_SCAN) || (state == S_FIN))
    else $error("request taken without starting work");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free |=> m_tvalid && (state == S_IDLE))
    else $error("finished request did not produce a result");

endmodule
